@@ rtl/core/cascaded_moving_average_core_assert.svh @@
// Assertion macros for the cascaded moving average core.
// Define NO_ASSERTIONS to compile them out.
`ifndef CASCADED_MOVING_AVERAGE_CORE_ASSERT_SVH
`define CASCADED_MOVING_AVERAGE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset.
`define CMA_ASSERT(name, clock, reset, prop) \
  name: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("cascaded moving average check failed");

// Checked on every edge, reset included.
`define CMA_ASSERT_ALWAYS(name, clock, prop) \
  name: assert property (@(posedge clock) prop) \
    else $error("cascaded moving average check failed");

`else

`define CMA_ASSERT(name, clock, reset, prop)
`define CMA_ASSERT_ALWAYS(name, clock, prop)

`endif

`endif

@@ rtl/core/cma_pkg.sv @@
package cma_pkg;

  localparam int WORD_W   = 16;
  localparam int COUNT_W  = 14;
  localparam int RESULT_W = 26;
  localparam int ORDER_W  = 2;

  localparam logic [ORDER_W-1:0] ORDER_NONE  = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_ONE   = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_TWO   = 2'd2;
  localparam logic [ORDER_W-1:0] ORDER_THREE = 2'd3;
  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_THREE;

  // Per-stage control from the top level.
  typedef struct packed {
    logic advance;  // whole pipeline moves this cycle
    logic push;     // a beat enters the stage
  } stage_ctrl_t;

endpackage

@@ rtl/core/cma_stage.sv @@
`include "cascaded_moving_average_core_assert.svh"

module cma_stage #(
  parameter int WINDOW = 16,
  parameter int IN_W   = 14,
  localparam int MEAN_W = IN_W + $clog2(WINDOW + 1) - 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cma_pkg::stage_ctrl_t ctl,
  input  logic [IN_W-1:0]      x,
  output logic                 mean_valid,
  output logic [MEAN_W-1:0]    mean
);
  import cma_pkg::*;

  localparam int FRAC_W = $clog2(WINDOW + 1) - 1;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = IN_W + $clog2(WINDOW);
  localparam bit POW2   = (WINDOW & (WINDOW - 1)) == 0;

  logic [IN_W-1:0]   ring [WINDOW];
  logic [SLOT_W-1:0] slot;
  logic [FILL_W-1:0] fill;
  logic              push;

  logic              a_valid;
  logic              a_full;
  logic              a_emit;
  logic [IN_W-1:0]   a_x;
  logic [IN_W-1:0]   a_old;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic              b_valid;

  assign push = ctl.advance && ctl.push;

  // Old entry is read in the same cycle it is overwritten; the read returns the
  // value from WINDOW beats back, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (push) begin
      ring[slot] <= x;
    end
    if (ctl.advance) begin
      a_old <= ring[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      a_x    <= x;
      a_full <= fill == FILL_W'(WINDOW);
      a_emit <= fill >= FILL_W'(WINDOW - 1);
    end
  end

  assign sum_next = sum + SUM_W'(a_x) - (a_full ? SUM_W'(a_old) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      fill    <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      sum     <= '0;
    end else if (ctl.advance) begin
      a_valid <= ctl.push;
      b_valid <= a_valid && a_emit;
      if (ctl.push) begin
        slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
        if (fill != FILL_W'(WINDOW)) begin
          fill <= fill + 1'b1;
        end
      end
      if (a_valid) begin
        sum <= sum_next;
      end
    end
  end

  generate
    if (POW2) begin : g_exact
      // sum * 2^F / WINDOW is the sum itself
      assign mean_valid = b_valid;
      assign mean       = MEAN_W'(sum);
    end else begin : g_recip
      // floor(sum * 2^F / WINDOW) as sum times a rounded-up reciprocal of WINDOW,
      // low half of the constant into m_lo, then the high half added into m_prod.
      localparam int DIV_W     = SUM_W + FRAC_W;
      localparam int SHIFT     = DIV_W + $clog2(WINDOW);
      localparam int RECIP_W   = DIV_W + 1;
      localparam int LO_W      = RECIP_W / 2;
      localparam int HI_W      = RECIP_W - LO_W;
      localparam int LO_PROD_W = SUM_W + LO_W;
      localparam int HI_PROD_W = SUM_W + HI_W;
      localparam int PROD_W    = SUM_W + RECIP_W;
      localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
      localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
      localparam logic [LO_W-1:0]    RECIP_LO = RECIP[LO_W-1:0];
      localparam logic [HI_W-1:0]    RECIP_HI = RECIP[RECIP_W-1:LO_W];

      logic [SUM_W-1:0]     m_x;
      logic [LO_PROD_W-1:0] m_lo;
      logic [PROD_W-1:0]    m_prod;
      logic [1:0]           m_valid;

      always_ff @(posedge clk) begin
        if (ctl.advance) begin
          m_x    <= sum;
          m_lo   <= LO_PROD_W'(sum) * LO_PROD_W'(RECIP_LO);
          m_prod <= PROD_W'(m_lo) +
                    (PROD_W'(HI_PROD_W'(m_x) * HI_PROD_W'(RECIP_HI)) << LO_W);
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          m_valid <= '0;
        end else if (ctl.advance) begin
          m_valid <= {m_valid[0], b_valid};
        end
      end

      assign mean_valid = m_valid[1];
      assign mean       = m_prod[SUM_W + $clog2(WINDOW) +: MEAN_W];
    end
  endgenerate

  `CMA_ASSERT(a_fill_bound, clk, rst, fill <= FILL_W'(WINDOW))
  `CMA_ASSERT(a_mean_needs_full, clk, rst, b_valid |-> fill == FILL_W'(WINDOW))
  `CMA_ASSERT(a_sum_frozen, clk, rst, (!$past(ctl.advance) && !$past(rst)) |-> $stable(sum))
  `CMA_ASSERT_ALWAYS(a_sum_cleared, clk, $past(rst) |-> (sum == '0 && fill == '0))

endmodule

@@ rtl/core/cascaded_moving_average_core.sv @@
// Pipeline: a beat passes each stage up to the selected one (input register, then running
//   sum), then the output register; other windows add the m_lo and m_prod registers per stage.
// Throughput: one beat per cycle unless a finished result is stalled; each stage does
//   one ring read, one write and one add/subtract per beat, read and write in the same cycle.
// Reset (rst, synchronous): sums, fill counts and slots cleared, order_sel back to 3,
//   ring contents left as they are.
module cascaded_moving_average_core #(
  parameter int WINDOW = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cma_pkg::ORDER_W-1:0]  filter_order,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cma_pkg::WORD_W-1:0]   sensor_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cma_pkg::RESULT_W-1:0] mean_value
);
  import cma_pkg::*;

  localparam int FRAC_W = $clog2(WINDOW + 1) - 1;
  localparam int M1_W   = COUNT_W + FRAC_W;
  localparam int M2_W   = COUNT_W + 2 * FRAC_W;
  localparam int M3_W   = COUNT_W + 3 * FRAC_W;
  localparam int PICK_W = (M3_W > RESULT_W) ? M3_W : RESULT_W;

  logic [ORDER_W-1:0] order_sel;
  logic [ORDER_W-1:0] sel_eff;
  logic               advance;

  stage_ctrl_t        ctl1;
  stage_ctrl_t        ctl2;
  stage_ctrl_t        ctl3;
  logic               s1_valid;
  logic               s2_valid;
  logic               s3_valid;
  logic [M1_W-1:0]    s1_mean;
  logic [M2_W-1:0]    s2_mean;
  logic [M3_W-1:0]    s3_mean;

  logic               pick_valid;
  logic [PICK_W-1:0]  pick;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_sel <= ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      order_sel <= filter_order;
    end
  end

  assign sel_eff = (order_sel == ORDER_NONE) ? ORDER_ONE : order_sel;

  // Whole pipeline holds while a finished result is stalled.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  assign ctl1.advance = advance;
  assign ctl1.push    = in_valid;
  assign ctl2.advance = advance;
  assign ctl2.push    = s1_valid && (sel_eff != ORDER_ONE);
  assign ctl3.advance = advance;
  assign ctl3.push    = s2_valid && (sel_eff == ORDER_THREE);

  cma_stage #(.WINDOW(WINDOW), .IN_W(COUNT_W)) u_stage1 (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl1),
    .x          (sensor_word[COUNT_W-1:0]),
    .mean_valid (s1_valid),
    .mean       (s1_mean)
  );

  cma_stage #(.WINDOW(WINDOW), .IN_W(M1_W)) u_stage2 (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl2),
    .x          (s1_mean),
    .mean_valid (s2_valid),
    .mean       (s2_mean)
  );

  cma_stage #(.WINDOW(WINDOW), .IN_W(M2_W)) u_stage3 (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl3),
    .x          (s2_mean),
    .mean_valid (s3_valid),
    .mean       (s3_mean)
  );

  // Align every stage to 3*F fraction bits.
  always_comb begin
    case (sel_eff)
      ORDER_TWO: begin
        pick_valid = s2_valid;
        pick       = PICK_W'(s2_mean) << FRAC_W;
      end
      ORDER_THREE: begin
        pick_valid = s3_valid;
        pick       = PICK_W'(s3_mean);
      end
      default: begin
        pick_valid = s1_valid;
        pick       = PICK_W'(s1_mean) << (2 * FRAC_W);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pick_valid) begin
      mean_value <= pick[RESULT_W-1:0];
    end
  end

endmodule
